FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL of this block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: hw/rtl/bbcw_pkg.sv
// ---------------------------------------------------------------------------
// bbcw_pkg
// Types and fixed constants shared by the clamped-window box blur.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bbcw_pkg;

   // fixed field widths
   localparam int DATA_BITS  = 16;   // channel in/out width
   localparam int POS_BITS   = 10;   // out_column / out_row width
   localparam int ROW_BITS   = 11;   // frame row counter incl. flush rows
   localparam int MAX_HEIGHT = 1024;
   localparam int CFG_BITS   = 11;   // width/height register width
   localparam int RAD_BITS   = 4;    // radius register width

   // controller -> datapath
   typedef struct packed {
      logic capture;     // latch transaction payload
      logic update;      // write column sum and row store
      logic out_init;    // set first/last output column
      logic sum_start;   // begin horizontal sum of one window
      logic div_start;   // begin division by clipped count
      logic out_load;    // load result register
      logic next_ox;     // step to next output column
      logic advance;     // step input position
   } bbcw_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic ignore;      // padding during image rows
      logic has_out;     // this position releases results
      logic ox_last;     // current output column is the last one
      logic sum_busy;
      logic div_busy;
      logic out_free;    // result register can take a new value
   } bbcw_status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/bbcw_div.sv
// ---------------------------------------------------------------------------
// bbcw_div
// Restoring divider, one quotient bit per cycle, three channels in lockstep.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbcw_div #(
   parameter int NW  = 26,
   parameter int DVW = 10
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [2:0][NW-1:0]     dividend,
   input  wire logic [DVW-1:0]         divisor,
   output logic                        busy,
   output logic [2:0][NW-1:0]          quotient
);
   localparam int IW = $clog2(NW + 1);

   logic                   busy_ff;
   logic [IW-1:0]          iter_ff;
   logic [DVW-1:0]         div_ff;
   logic [2:0][NW-1:0]     q_ff, q_in;
   logic [2:0][DVW:0]      rem_ff, rem_in;

   // one restoring step per channel
   always_comb begin
      logic [DVW:0] shifted;
      for (int k = 0; k < 3; k++) begin
         shifted = {rem_ff[k][DVW-1:0], q_ff[k][NW-1]};
         if (shifted >= {1'b0, div_ff}) begin
            rem_in[k] = shifted - {1'b0, div_ff};
            q_in[k]   = {q_ff[k][NW-2:0], 1'b1};
         end else begin
            rem_in[k] = shifted;
            q_in[k]   = {q_ff[k][NW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iter_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         iter_ff <= IW'(NW);
      end else if (busy_ff) begin
         iter_ff <= iter_ff - IW'(1);
         if (iter_ff == IW'(1)) busy_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/bbcw_dp.sv
// ---------------------------------------------------------------------------
// bbcw_dp
// Datapath: position counters, row store, column sums, window sum,
// divider and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbcw_dp #(
   parameter int MAX_WIDTH    = 1024,
   parameter int MAX_RADIUS   = 15,
   parameter int CHANNEL_BITS = 16,
   parameter int XW           = $clog2(MAX_WIDTH),
   parameter int RW           = $clog2(MAX_RADIUS + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         restart,
   input  wire bbcw_pkg::bbcw_cmd_type       cmd,
   output bbcw_pkg::bbcw_status_type         status,
   input  wire logic [RW-1:0]                r_eff,
   input  wire logic [XW:0]                  w_eff,
   input  wire logic [bbcw_pkg::ROW_BITS-1:0] h_eff,
   input  wire logic                         req_command,
   input  wire logic [bbcw_pkg::DATA_BITS-1:0] req_red_in,
   input  wire logic [bbcw_pkg::DATA_BITS-1:0] req_green_in,
   input  wire logic [bbcw_pkg::DATA_BITS-1:0] req_blue_in,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [bbcw_pkg::DATA_BITS-1:0]    rsp_red_mean,
   output logic [bbcw_pkg::DATA_BITS-1:0]    rsp_green_mean,
   output logic [bbcw_pkg::DATA_BITS-1:0]    rsp_blue_mean,
   output logic [bbcw_pkg::POS_BITS-1:0]     rsp_out_column,
   output logic [bbcw_pkg::POS_BITS-1:0]     rsp_out_row,
   output logic                              rsp_last_of_run
);
   import bbcw_pkg::*;

   localparam int WW         = XW + 1;
   localparam int HW         = XW + 2;
   localparam int YW         = ROW_BITS;
   localparam int STORE_ROWS = 2 * MAX_RADIUS + 1;
   localparam int SW         = $clog2(STORE_ROWS);
   localparam int VB         = (CHANNEL_BITS < DATA_BITS) ? CHANNEL_BITS : DATA_BITS;
   localparam int DW         = $clog2(STORE_ROWS + 1);
   localparam int CSW        = VB + DW;
   localparam int HSW        = CSW + DW;
   localparam int CW         = 2 * DW;
   localparam int RS_DEPTH   = STORE_ROWS << XW;

   // memories
   logic [2:0][CSW-1:0] cs_mem [MAX_WIDTH];
   logic [2:0][VB-1:0]  rs_mem [RS_DEPTH];
   logic [2:0][CSW-1:0] cs_rd_ff;
   logic [2:0][VB-1:0]  rs_rd_ff;

   // captured transaction
   logic                command_ff;
   logic [2:0][VB-1:0]  pix_ff;

   // input position
   logic [XW-1:0]       col_ff;
   logic [YW-1:0]       row_ff;
   logic [SW-1:0]       slot_ff;

   // output run and window sum
   logic [XW-1:0]       ox_ff, last_ff;
   logic [XW-1:0]       sum_col_ff, sum_end_ff;
   logic                sum_issue_ff, sum_valid_ff;
   logic [2:0][HSW-1:0] acc_ff;
   logic [CW-1:0]       count_ff;

   // result register
   logic                out_valid_ff;
   logic [2:0][DATA_BITS-1:0] mean_ff;
   logic [POS_BITS-1:0] out_col_ff, out_row_ff;
   logic                out_last_ff;

   logic                div_busy;
   logic [2:0][HSW-1:0] quotient;

   // derived position terms
   logic [YW-1:0]   r_y, r2_y, span_y, vlo_y, vhi_y, h_m1;
   logic            flushing, old_valid, col_last;
   logic [SW:0]     span_s, slot_x, old_slot_x;
   logic [SW-1:0]   old_slot;
   logic [WW-1:0]   col_w, r_w, w_last, first_w, last_w;
   logic [HW-1:0]   ox_h, r_h, hlo_h, hhi_h, ohi_h;
   logic [DW-1:0]   hspan, vspan;
   logic [XW-1:0]   cs_raddr;
   logic [2:0][CSW-1:0] cs_new;

   always_comb begin
      r_y      = YW'(r_eff);
      r2_y     = YW'({r_eff, 1'b0});
      span_y   = r2_y + YW'(1);
      flushing = (row_ff >= h_eff);
      old_valid = (row_ff >= span_y) && ((row_ff - span_y) < h_eff);

      // store row that leaves the vertical window
      span_s     = (SW + 1)'({r_eff, 1'b0}) + (SW + 1)'(1);
      slot_x     = {1'b0, slot_ff};
      old_slot_x = (slot_x >= span_s) ? slot_x - span_s
                                      : slot_x + (SW + 1)'(STORE_ROWS) - span_s;
      old_slot   = old_slot_x[SW-1:0];

      // output run of this position
      col_w    = WW'(col_ff);
      r_w      = WW'(r_eff);
      w_last   = w_eff - WW'(1);
      col_last = (col_w == w_last);
      first_w  = (col_w >= r_w) ? col_w - r_w : '0;
      last_w   = col_last ? col_w : col_w - r_w;

      // clipped window of the current output column
      ox_h   = HW'(ox_ff);
      r_h    = HW'(r_eff);
      hlo_h  = (ox_h >= r_h) ? ox_h - r_h : '0;
      ohi_h  = ox_h + r_h;
      hhi_h  = (ohi_h > HW'(w_last)) ? HW'(w_last) : ohi_h;
      hspan  = DW'(hhi_h - hlo_h + HW'(1));
      h_m1   = h_eff - YW'(1);
      vlo_y  = (row_ff >= r2_y) ? row_ff - r2_y : '0;
      vhi_y  = (row_ff < h_m1) ? row_ff : h_m1;
      vspan  = DW'(vhi_y - vlo_y + YW'(1));

      // new column sum: row 0 starts the frame from zero
      for (int k = 0; k < 3; k++) begin
         cs_new[k] = ((row_ff == '0) ? '0 : cs_rd_ff[k])
                   - (old_valid ? CSW'(rs_rd_ff[k]) : '0)
                   + (flushing ? '0 : CSW'(pix_ff[k]));
      end

      cs_raddr = sum_issue_ff ? sum_col_ff : col_ff;
   end

   // memories: registered reads every cycle, writes on update
   always_ff @(posedge clock) begin
      cs_rd_ff <= cs_mem[cs_raddr];
      rs_rd_ff <= rs_mem[{old_slot, col_ff}];
      if (cmd.update) begin
         cs_mem[col_ff] <= cs_new;
         if (!flushing) rs_mem[{slot_ff, col_ff}] <= pix_ff;
      end
   end

   // transaction capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         command_ff <= req_command;
         pix_ff[0]  <= VB'(req_red_in);
         pix_ff[1]  <= VB'(req_green_in);
         pix_ff[2]  <= VB'(req_blue_in);
      end
   end

   // input position
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else if (cmd.advance) begin
         if (col_last) begin
            col_ff <= '0;
            if ((row_ff + YW'(1)) >= (h_eff + r_y)) begin
               row_ff  <= '0;
               slot_ff <= '0;
            end else begin
               row_ff  <= row_ff + YW'(1);
               slot_ff <= (slot_ff == SW'(STORE_ROWS - 1)) ? '0 : slot_ff + SW'(1);
            end
         end else begin
            col_ff <= col_ff + XW'(1);
         end
      end
   end

   // output column run
   always_ff @(posedge clock) begin
      if (cmd.out_init) begin
         ox_ff   <= XW'(first_w);
         last_ff <= XW'(last_w);
      end else if (cmd.next_ox) begin
         ox_ff   <= ox_ff + XW'(1);
      end
   end

   // horizontal sum sequencer control
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_issue_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else if (cmd.sum_start) begin
         sum_issue_ff <= 1'b1;
         sum_valid_ff <= 1'b0;
      end else begin
         if (sum_issue_ff && (sum_col_ff == sum_end_ff)) sum_issue_ff <= 1'b0;
         sum_valid_ff <= sum_issue_ff;
      end
   end

   // horizontal sum payload
   always_ff @(posedge clock) begin
      if (cmd.sum_start) begin
         sum_col_ff <= XW'(hlo_h);
         sum_end_ff <= XW'(hhi_h);
         acc_ff     <= '0;
         count_ff   <= CW'(hspan) * CW'(vspan);
      end else begin
         if (sum_issue_ff) sum_col_ff <= sum_col_ff + XW'(1);
         if (sum_valid_ff) begin
            for (int k = 0; k < 3; k++) acc_ff[k] <= acc_ff[k] + HSW'(cs_rd_ff[k]);
         end
      end
   end

   bbcw_div #(
      .NW  (HSW),
      .DVW (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (acc_ff),
      .divisor  (count_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         for (int k = 0; k < 3; k++) mean_ff[k] <= DATA_BITS'(quotient[k]);
         out_col_ff  <= POS_BITS'(ox_ff);
         out_row_ff  <= POS_BITS'(row_ff - r_y);
         out_last_ff <= (ox_ff == last_ff);
      end
   end

   // status
   always_comb begin
      status.ignore   = !flushing && command_ff;
      status.has_out  = (row_ff >= r_y) && (col_last || (col_w >= r_w));
      status.ox_last  = (ox_ff == last_ff);
      status.sum_busy = sum_issue_ff || sum_valid_ff;
      status.div_busy = div_busy;
      status.out_free = !out_valid_ff || !rsp_stall;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_red_mean    = mean_ff[0];
   assign rsp_green_mean  = mean_ff[1];
   assign rsp_blue_mean   = mean_ff[2];
   assign rsp_out_column  = out_col_ff;
   assign rsp_out_row     = out_row_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/bbcw_ctrl.sv
// ---------------------------------------------------------------------------
// bbcw_ctrl
// Controller: sequences one transaction through update, window sums,
// division and result hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bbcw_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   output bbcw_pkg::bbcw_cmd_type          cmd,
   input  wire bbcw_pkg::bbcw_status_type  status
);
   import bbcw_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_UPDATE,
      ST_HSTART,
      ST_HSUM,
      ST_DIVIDE,
      ST_OUTPUT,
      ST_ADVANCE
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // memory reads for the update are issued here
            state_in = status.ignore ? ST_IDLE : ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update   = 1'b1;
            cmd.out_init = 1'b1;
            state_in     = status.has_out ? ST_HSTART : ST_ADVANCE;
         end
         ST_HSTART: begin
            cmd.sum_start = 1'b1;
            state_in      = ST_HSUM;
         end
         ST_HSUM: begin
            if (!status.sum_busy) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (!status.div_busy) state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (status.ox_last) begin
                  state_in = ST_ADVANCE;
               end else begin
                  cmd.next_ox = 1'b1;
                  state_in    = ST_HSTART;
               end
            end
         end
         ST_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in    = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   `ASSERT_CLK(a_load_free, clock, reset, cmd.out_load |-> status.out_free, "result overwritten")
   `ASSERT_CLK(a_accept_check, clock, reset,
      (state_ff == ST_IDLE && req_valid) |=> (state_ff == ST_CHECK), "accept not checked")
   `ASSERT_CLK(a_sum_runs, clock, reset, cmd.sum_start |=> status.sum_busy, "sum did not start")
   `ASSERT_NEVER(a_div_overlap, clock, reset, cmd.div_start && status.div_busy,
      "divider restarted while busy")

endmodule

`default_nettype wire

FILE: hw/rtl/box_blur_clamped_window.sv
// ---------------------------------------------------------------------------
// box_blur_clamped_window
// Streaming RGB box blur over a (2r+1)x(2r+1) window clipped at the image
// borders, with an APB-style register port.
// ---------------------------------------------------------------------------
// A transaction without results passes IDLE, CHECK, UPDATE and ADVANCE;
// padding during image rows returns from CHECK to IDLE. Each result adds
// HSTART, HSUM (column-sum reads through the single read port of the
// column-sum memory), DIVIDE (bit-serial, over the window sum, 26 bits at
// default parameters) and OUTPUT; transactions do not overlap. Results lag
// the input by r rows and r columns; the last pixel of a row releases r+1
// results and r rows of padding transactions flush the frame. No clearing
// pass is needed after reset or a register write: row 0 of every frame
// rebuilds the column sums. Any register write restarts the frame at row 0.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module box_blur_clamped_window #(
   parameter int MAX_WIDTH    = 1024,
   parameter int MAX_RADIUS   = 15,
   parameter int CHANNEL_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_command,
   input  wire logic [15:0] req_red_in,
   input  wire logic [15:0] req_green_in,
   input  wire logic [15:0] req_blue_in,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_red_mean,
   output logic [15:0]      rsp_green_mean,
   output logic [15:0]      rsp_blue_mean,
   output logic [9:0]       rsp_out_column,
   output logic [9:0]       rsp_out_row,
   output logic             rsp_last_of_run,
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import bbcw_pkg::*;

   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int WW   = XW + 1;
   localparam int RW   = $clog2(MAX_RADIUS + 1);
   localparam int CMPW = (WW > CFG_BITS) ? WW : CFG_BITS;
   localparam int CMPR = (RW > RAD_BITS) ? RW : RAD_BITS;

   localparam logic [1:0] REG_RADIUS = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   logic [RAD_BITS-1:0] radius_ff;
   logic [CFG_BITS-1:0] width_ff, height_ff;
   logic                csr_write;
   logic [1:0]          reg_index;

   logic [CMPW-1:0]     wide_w;
   logic [CMPR-1:0]     wide_r;
   logic [RW-1:0]       r_eff;
   logic [WW-1:0]       w_eff;
   logic [ROW_BITS-1:0] h_eff;

   bbcw_cmd_type        cmd;
   bbcw_status_type     status;

   // register writes
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RAD_BITS'(2);
         width_ff  <= CFG_BITS'(1024);
         height_ff <= CFG_BITS'(1024);
      end else if (csr_write) begin
         case (reg_index)
            REG_RADIUS: radius_ff <= csr_pwdata[RAD_BITS-1:0];
            REG_WIDTH:  width_ff  <= csr_pwdata[CFG_BITS-1:0];
            REG_HEIGHT: height_ff <= csr_pwdata[CFG_BITS-1:0];
            default:    ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (reg_index)
         REG_RADIUS: csr_prdata = 32'(radius_ff);
         REG_WIDTH:  csr_prdata = 32'(width_ff);
         REG_HEIGHT: csr_prdata = 32'(height_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // saturate register values to the supported range
   always_comb begin
      wide_r = CMPR'(radius_ff);
      r_eff  = (wide_r > CMPR'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(wide_r);

      wide_w = CMPW'(width_ff);
      if (wide_w == '0) begin
         w_eff = WW'(1);
      end else if (wide_w > CMPW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(wide_w);
      end

      if (height_ff == '0) begin
         h_eff = ROW_BITS'(1);
      end else if (height_ff > CFG_BITS'(MAX_HEIGHT)) begin
         h_eff = ROW_BITS'(MAX_HEIGHT);
      end else begin
         h_eff = ROW_BITS'(height_ff);
      end
   end

   bbcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   bbcw_dp #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_RADIUS   (MAX_RADIUS),
      .CHANNEL_BITS (CHANNEL_BITS),
      .XW           (XW),
      .RW           (RW)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .restart         (csr_write),
      .cmd             (cmd),
      .status          (status),
      .r_eff           (r_eff),
      .w_eff           (w_eff),
      .h_eff           (h_eff),
      .req_command     (req_command),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red_mean    (rsp_red_mean),
      .rsp_green_mean  (rsp_green_mean),
      .rsp_blue_mean   (rsp_blue_mean),
      .rsp_out_column  (rsp_out_column),
      .rsp_out_row     (rsp_out_row),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire
